[sv/msed_pkg.sv]
// Package: shared constants, entity tables and transaction types for the markup stripper.
`timescale 1ns / 1ps

package msed_pkg;

    localparam int LIMIT_MAX  = 4095;
    localparam int LIMIT_W    = 12;
    localparam int HELD_DEPTH = 5;
    localparam int NUM_ENT    = 5;
    localparam int CQ_DEPTH   = 4;
    localparam int OQ_DEPTH   = 4;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 3;

    // Word address of the output_limit register
    localparam logic ADDR_OUTPUT_LIMIT = 1'b0;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_B_LO  = 8'h62;
    localparam logic [7:0] CH_B_UP  = 8'h42;
    localparam logic [7:0] CH_R_LO  = 8'h72;
    localparam logic [7:0] CH_R_UP  = 8'h52;

    typedef logic [7:0] t_byte;
    typedef t_byte [0:7] t_ent_row;

    // Entity spellings, zero padded: amp, lt, gt, quot, apos
    localparam t_ent_row ENT_TEXT [NUM_ENT] = '{
        '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00, 8'h00, 8'h00},
        '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B, 8'h00, 8'h00},
        '{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B, 8'h00, 8'h00}
    };
    localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6};
    localparam t_byte ENT_VAL [NUM_ENT] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};

    // Work for the back end: replay held bytes, then an optional byte or end marker
    typedef struct packed {
        logic [2:0]                  rep_cnt;
        t_byte [0:HELD_DEPTH-1]      rep_bytes;
        logic                        has_byte;
        t_byte                       byte_val;
        logic                        is_end;
    } t_cmd;

    typedef struct packed {
        t_byte out_byte;
        logic  byte_valid;
        logic  text_end;
        logic  truncated;
    } t_res;

endpackage

[sv/msed_front.sv]
// Front end: scans input bytes, tracks tags and entity prefixes, builds back-end commands.
`timescale 1ns / 1ps

module msed_front
    import msed_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  logic  i_op,
    input  t_byte i_in_byte,
    output logic  o_cmd_push,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        M_NORMAL   = 3'd0,
        M_TAG_OPEN = 3'd1,
        M_TAG_B    = 3'd2,
        M_TAG_SKIP = 3'd3,
        M_ENTITY   = 3'd4
    } t_mode;

    t_mode      r_mode, n_mode;
    t_byte      r_held [HELD_DEPTH];
    logic [2:0] r_cnt, n_cnt;
    logic       held_wr;
    logic [2:0] held_wr_idx;

    // plain-text decode of the incoming byte
    t_mode p_mode;
    logic  p_emit;
    t_byte p_byte;
    logic  p_hold;

    // entity matching
    logic [NUM_ENT-1:0] ent_hit;
    logic               ent_full, ent_partial;
    t_byte              ent_value;
    logic               pre_ok;

    always_comb begin
        p_mode = M_NORMAL;
        p_emit = 1'b0;
        p_byte = i_in_byte;
        p_hold = 1'b0;
        if (i_in_byte == CH_LT) begin
            p_mode = M_TAG_OPEN;
        end else if (i_in_byte == CH_AMP) begin
            p_mode = M_ENTITY;
            p_hold = 1'b1;
        end else if (i_in_byte == CH_CR) begin
            p_emit = 1'b0;
        end else if (i_in_byte == CH_TAB) begin
            p_emit = 1'b1;
            p_byte = CH_SPACE;
        end else begin
            p_emit = 1'b1;
        end
    end

    always_comb begin
        ent_full    = 1'b0;
        ent_partial = 1'b0;
        ent_value   = '0;
        ent_hit     = '0;
        pre_ok      = 1'b0;
        for (int e = 0; e < NUM_ENT; e++) begin
            pre_ok = 1'b1;
            for (int i = 0; i < HELD_DEPTH; i++) begin
                if ((3'(i) < r_cnt) && (r_held[i] != ENT_TEXT[e][i])) begin
                    pre_ok = 1'b0;
                end
            end
            ent_hit[e] = pre_ok && (r_cnt < ENT_LEN[e]) && (i_in_byte == ENT_TEXT[e][r_cnt]);
            if (ent_hit[e]) begin
                if ((r_cnt + 3'd1) == ENT_LEN[e]) begin
                    ent_full  = 1'b1;
                    ent_value = ENT_VAL[e];
                end else begin
                    ent_partial = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_mode          = r_mode;
        n_cnt           = r_cnt;
        held_wr         = 1'b0;
        held_wr_idx     = '0;
        o_cmd.rep_cnt   = '0;
        o_cmd.has_byte  = 1'b0;
        o_cmd.byte_val  = '0;
        o_cmd.is_end    = 1'b0;
        for (int i = 0; i < HELD_DEPTH; i++) begin
            o_cmd.rep_bytes[i] = r_held[i];
        end

        if (i_op) begin
            if (r_mode == M_ENTITY) begin
                o_cmd.rep_cnt = r_cnt;
            end
            o_cmd.is_end = 1'b1;
            n_mode       = M_NORMAL;
            n_cnt        = '0;
        end else begin
            unique case (r_mode)
                M_TAG_OPEN: begin
                    if (i_in_byte == CH_GT) begin
                        n_mode = M_NORMAL;
                    end else if (i_in_byte == CH_B_LO || i_in_byte == CH_B_UP) begin
                        n_mode = M_TAG_B;
                    end else begin
                        n_mode = M_TAG_SKIP;
                    end
                end
                M_TAG_B: begin
                    if (i_in_byte == CH_R_LO || i_in_byte == CH_R_UP) begin
                        o_cmd.has_byte = 1'b1;
                        o_cmd.byte_val = CH_LF;
                        n_mode         = M_TAG_SKIP;
                    end else if (i_in_byte == CH_GT) begin
                        n_mode = M_NORMAL;
                    end else begin
                        n_mode = M_TAG_SKIP;
                    end
                end
                M_TAG_SKIP: begin
                    if (i_in_byte == CH_GT) begin
                        n_mode = M_NORMAL;
                    end
                end
                M_ENTITY: begin
                    if (ent_full) begin
                        o_cmd.has_byte = 1'b1;
                        o_cmd.byte_val = ent_value;
                        n_mode         = M_NORMAL;
                        n_cnt          = '0;
                    end else if (ent_partial && (r_cnt < 3'(HELD_DEPTH))) begin
                        held_wr     = 1'b1;
                        held_wr_idx = r_cnt;
                        n_cnt       = r_cnt + 3'd1;
                    end else begin
                        // mismatch: replay the prefix, then treat the byte as plain text
                        o_cmd.rep_cnt  = r_cnt;
                        o_cmd.has_byte = p_emit;
                        o_cmd.byte_val = p_byte;
                        n_mode         = p_mode;
                        n_cnt          = p_hold ? 3'd1 : 3'd0;
                        held_wr        = p_hold;
                        held_wr_idx    = '0;
                    end
                end
                default: begin
                    o_cmd.has_byte = p_emit;
                    o_cmd.byte_val = p_byte;
                    n_mode         = p_mode;
                    n_cnt          = p_hold ? 3'd1 : 3'd0;
                    held_wr        = p_hold;
                    held_wr_idx    = '0;
                end
            endcase
        end

        o_cmd_push = i_accept &&
                     ((o_cmd.rep_cnt != '0) || o_cmd.has_byte || o_cmd.is_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL;
            r_cnt  <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && held_wr) begin
            r_held[held_wr_idx] <= i_in_byte;
        end
    end

endmodule

[sv/msed_cmdq.sv]
// Command queue between the front end and the back end.
`timescale 1ns / 1ps

module msed_cmdq
    import msed_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    localparam int PTR_W = $clog2(CQ_DEPTH);

    t_cmd                r_mem [CQ_DEPTH];
    logic [PTR_W-1:0]    r_wp, r_rp;
    logic [PTR_W:0]      r_cnt;
    logic                do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (PTR_W+1)'(CQ_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

[sv/msed_back.sv]
// Back end: steps through commands, applies the output limit, queues results.
`timescale 1ns / 1ps

module msed_back
    import msed_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_cmd_empty,
    output logic               o_cmd_pop,
    input  logic [LIMIT_W-1:0] i_limit,
    input  logic               i_pop,
    output t_res               o_res,
    output logic               o_empty
);

    localparam int PTR_W = $clog2(OQ_DEPTH);

    logic [2:0]         r_idx;
    logic [LIMIT_W-1:0] r_emitted;
    logic               r_dropped;

    t_res               r_oq [OQ_DEPTH];
    logic [PTR_W-1:0]   r_wp, r_rp;
    logic [PTR_W:0]     r_oq_cnt;

    logic               step, at_rep, fin, last, is_emit, is_end_step, below, oq_push, oq_pop;
    logic [16:0]        lim;
    t_byte              step_byte;
    t_res               res;

    always_comb begin
        lim         = (17'(i_limit) < 17'(LIMIT_MAX)) ? 17'(i_limit) : 17'(LIMIT_MAX);
        below       = 17'(r_emitted) < lim;
        step        = !i_cmd_empty && (r_oq_cnt != (PTR_W+1)'(OQ_DEPTH));
        at_rep      = r_idx < i_cmd.rep_cnt;
        fin         = i_cmd.has_byte || i_cmd.is_end;
        last        = (4'(r_idx) + 4'd1) == (4'(i_cmd.rep_cnt) + 4'(fin));
        is_emit     = at_rep || i_cmd.has_byte;
        is_end_step = !at_rep && i_cmd.is_end;
        step_byte   = at_rep ? i_cmd.rep_bytes[r_idx] : i_cmd.byte_val;

        res.out_byte   = is_end_step ? 8'h00 : step_byte;
        res.byte_valid = !is_end_step;
        res.text_end   = is_end_step;
        res.truncated  = r_dropped;

        oq_push   = step && (is_end_step || (is_emit && below));
        oq_pop    = i_pop && !o_empty;
        o_cmd_pop = step && last;
    end

    assign o_empty = (r_oq_cnt == '0);
    assign o_res   = r_oq[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_emitted <= '0;
            r_dropped <= 1'b0;
            r_wp      <= '0;
            r_rp      <= '0;
            r_oq_cnt  <= '0;
        end else begin
            if (step) begin
                r_idx <= last ? 3'd0 : r_idx + 3'd1;
                if (is_end_step) begin
                    r_emitted <= '0;
                    r_dropped <= 1'b0;
                end else if (is_emit) begin
                    if (below) begin
                        r_emitted <= r_emitted + 1'b1;
                    end else begin
                        r_dropped <= 1'b1;
                    end
                end
            end
            if (oq_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (oq_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (oq_push && !oq_pop) begin
                r_oq_cnt <= r_oq_cnt + 1'b1;
            end else if (oq_pop && !oq_push) begin
                r_oq_cnt <= r_oq_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_wp] <= res;
        end
    end

endmodule

[sv/markup_strip_entity_decode_top.sv]
// Top level: markup stripper with entity decoding, queue ports and APB register port.
// Path: accepted input goes into the command queue, then its results into the result queue.
// Throughput: one input transaction per cycle while full is low and each yields at most
//   one result; the back end moves one result per cycle while the result queue has room;
//   a replayed entity prefix and its byte give up to six results, and the four-entry
//   command queue absorbs that burst.
// Reset: i_rst_n is synchronous, active low; clears scan state, counters and queues,
//   and sets output_limit to 4095. No clearing pass is needed.
`timescale 1ns / 1ps

module markup_strip_entity_decode_top
    import msed_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input queue side
    input  logic               push,
    output logic               full,
    input  logic               i_op,
    input  logic [7:0]         i_in_byte,
    // result queue side
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         o_out_byte,
    output logic               o_byte_valid,
    output logic               o_text_end,
    output logic               o_truncated,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic [LIMIT_W-1:0] r_output_limit;
    logic               in_accept;
    logic               cmd_push, cmd_pop, cmd_empty, cmd_full;
    t_cmd               cmd_in, cmd_head;
    t_res               res;

    // Register port: zero wait states; byte lanes within a word are ignored
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_OUTPUT_LIMIT) ? DATA_W'(r_output_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_limit <= LIMIT_W'(LIMIT_MAX);
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == ADDR_OUTPUT_LIMIT)) begin
            r_output_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    // Accept a transaction whenever the command queue has room
    assign full      = cmd_full;
    assign in_accept = push && !full;

    msed_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_op       (i_op),
        .i_in_byte  (i_in_byte),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    // Decouple scanning from result delivery
    msed_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_head  (cmd_head),
        .o_empty (cmd_empty),
        .o_full  (cmd_full)
    );

    // Apply the limit, count emitted bytes and hold results until popped
    msed_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_head),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_limit     (r_output_limit),
        .i_pop       (pop),
        .o_res       (res),
        .o_empty     (empty)
    );

    assign o_out_byte   = res.out_byte;
    assign o_byte_valid = res.byte_valid;
    assign o_text_end   = res.text_end;
    assign o_truncated  = res.truncated;

endmodule
